### design/tsm_pkg.sv
// Shared types and constants for the time-signature map unit.
// Depends on nothing; imported by every module of the block.
package tsm_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [11:0] TPQ_RESET   = 12'd480;
   localparam logic [7:0]  DEFAULT_NUM = 8'd4;
   localparam logic [6:0]  DEFAULT_DEN = 7'd4;

   localparam logic [1:0] CMD_INSERT      = 2'd0;
   localparam logic [1:0] CMD_TICK_TO_LOC = 2'd1;
   localparam logic [1:0] CMD_LOC_TO_TICK = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [30:0] tick_value;
      logic [15:0] measure_in;
      logic [7:0]  beat_in;
      logic [7:0]  sig_numerator;
      logic [6:0]  sig_denominator;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] result_tick;
      logic [15:0] measure_out;
      logic [7:0]  beat_out;
      logic [11:0] beat_tick_out;
   } rsp_type;

   typedef struct packed {
      logic [30:0] tick;
      logic [7:0]  num;
      logic [6:0]  den;
   } entry_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_READ_IDX,
      OP_INS_STEP,
      OP_REM_INIT,
      OP_READ_SP,
      OP_REM_WRITE,
      OP_CNT_DEC,
      OP_SET_DROP,
      OP_SET_FULL,
      OP_UP_INIT,
      OP_READ_SPM,
      OP_UP_WRITE,
      OP_INS_WRITE,
      OP_DIV_BL,
      OP_BL_SET,
      OP_ML_SET,
      OP_REL_CHG,
      OP_REL_FINAL,
      OP_DIV_REL,
      OP_DIV_REM,
      OP_MEAS_ADD,
      OP_ADVANCE,
      OP_T2L_FIN,
      OP_TGT_INIT,
      OP_MUL_STEP,
      OP_TGT_B,
      OP_SUB_M,
      OP_SUB_BT,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       idx_end;
      logic       sp_at_cnt;
      logic       sp_at_idx;
      logic       tick_eq;
      logic       tick_lt;
      logic       redundant;
      logic       full;
      logic       div_busy;
      logic       mul_zero;
      logic       t2l_stop;
      logic       l2t_stop;
   } dp_status_type;

endpackage

### design/tsm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tsm_pkg.
module tsm_div
   import tsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [30:0] dividend,
   input  logic [21:0] divisor,
   output logic        busy,
   output logic [30:0] quotient,
   output logic [21:0] remainder
);

   logic        busy_ff;
   logic [4:0]  cnt_ff;
   logic [30:0] q_ff;
   logic [21:0] rem_ff;
   logic [21:0] dvs_ff;
   logic [22:0] rem_sh;
   logic        ge;
   logic [22:0] diff;

   assign rem_sh = {rem_ff, q_ff[30]};
   assign ge     = rem_sh >= {1'b0, dvs_ff};
   assign diff   = rem_sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && cnt_ff == 5'd30) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= '0;
         q_ff   <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         q_ff   <= {q_ff[29:0], ge};
         rem_ff <= ge ? diff[21:0] : rem_sh[21:0];
      end
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

endmodule

### design/tsm_dpath.sv
// Datapath: change table memory, walk registers, serial multiplier, divider.
// Depends on tsm_pkg and tsm_div; driven by tsm_ctrl through dp_op_type.
module tsm_dpath
   import tsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [11:0]   csr_wr_data,
   input  req_type       req_data,
   input  dp_op_type     op,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   entry_type mem [TABLE_DEPTH];
   entry_type rdata_ff;
   logic                 mem_rd;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_raddr;
   logic [IDX_W-1:0]     mem_waddr;
   entry_type            mem_wdata;

   logic [11:0]        tpq_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   sp_ff;
   logic [CNT_W-1:0]   sp_m1;

   logic [1:0]   cmd_ff;
   logic [30:0]  tick_ff;
   logic [7:0]   num_ff;
   logic [6:0]   den_ff;
   logic [7:0]   prev_num_ff;
   logic [6:0]   prev_den_ff;
   logic [1:0]   status_ff;

   logic [7:0]   cur_num_ff;
   logic [6:0]   cur_den_ff;
   logic [7:0]   num_eff;
   logic [6:0]   den_eff;
   logic [13:0]  bl_ff;
   logic [21:0]  ml_ff;
   logic [30:0]  off_ff;
   logic [30:0]  rel_ff;

   logic [31:0]  meas_ff;
   logic [7:0]   beat_ff;
   logic [11:0]  bt_ff;

   logic signed [39:0] m_ff;
   logic signed [15:0] b_ff;
   logic signed [32:0] t_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] mcand_ff;
   logic [21:0]        mplier_ff;

   rsp_type rsp_ff;
   rsp_type rsp_next;

   logic        div_start;
   logic [30:0] div_dvd;
   logic [21:0] div_dvs;
   logic        div_busy;
   logic [30:0] div_q;
   logic [21:0] div_r;

   tsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .busy      (div_busy),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign sp_m1   = sp_ff - CNT_W'(1);
   assign num_eff = (cur_num_ff == 8'd0) ? 8'd1 : cur_num_ff;
   assign den_eff = (cur_den_ff == 7'd0) ? 7'd1 : cur_den_ff;

   always_comb begin
      mem_rd    = 1'b0;
      mem_raddr = idx_ff[IDX_W-1:0];
      mem_we    = 1'b0;
      mem_waddr = sp_ff[IDX_W-1:0];
      mem_wdata = rdata_ff;
      div_start = 1'b0;
      div_dvd   = rel_ff;
      div_dvs   = ml_ff;
      case (op)
         OP_READ_IDX: begin
            mem_rd = 1'b1;
         end
         OP_READ_SP: begin
            mem_rd    = 1'b1;
            mem_raddr = sp_ff[IDX_W-1:0];
         end
         OP_READ_SPM: begin
            mem_rd    = 1'b1;
            mem_raddr = sp_m1[IDX_W-1:0];
         end
         OP_REM_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = sp_m1[IDX_W-1:0];
         end
         OP_UP_WRITE: begin
            mem_we = 1'b1;
         end
         OP_INS_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[IDX_W-1:0];
            mem_wdata = '{tick: tick_ff, num: num_ff, den: den_ff};
         end
         OP_DIV_BL: begin
            div_start = 1'b1;
            div_dvd   = {17'd0, tpq_ff, 2'b00};
            div_dvs   = {15'd0, den_eff};
         end
         OP_DIV_REL: begin
            div_start = 1'b1;
         end
         OP_DIV_REM: begin
            div_start = 1'b1;
            div_dvd   = {9'd0, div_r};
            div_dvs   = {8'd0, bl_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpq_ff <= TPQ_RESET;
         cnt_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            tpq_ff <= csr_wr_data;
         end
         case (op)
            OP_CNT_DEC:   cnt_ff <= cnt_ff - CNT_W'(1);
            OP_INS_WRITE: cnt_ff <= cnt_ff + CNT_W'(1);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_next = '0;
      case (cmd_ff)
         CMD_INSERT: begin
            rsp_next.status = status_ff;
         end
         CMD_TICK_TO_LOC: begin
            rsp_next.measure_out   = (|meas_ff[31:16]) ? 16'hFFFF : meas_ff[15:0];
            rsp_next.beat_out      = beat_ff;
            rsp_next.beat_tick_out = bt_ff;
         end
         CMD_LOC_TO_TICK: begin
            if (acc_ff[63]) begin
               rsp_next.result_tick = '0;
            end else if (|acc_ff[62:31]) begin
               rsp_next.result_tick = 31'h7FFF_FFFF;
            end else begin
               rsp_next.result_tick = acc_ff[30:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_LOAD: begin
            cmd_ff     <= req_data.cmd;
            tick_ff    <= req_data.tick_value;
            num_ff     <= req_data.sig_numerator;
            den_ff     <= req_data.sig_denominator;
            idx_ff     <= '0;
            status_ff  <= ST_DONE;
            cur_num_ff <= DEFAULT_NUM;
            cur_den_ff <= DEFAULT_DEN;
            off_ff     <= '0;
            meas_ff    <= 32'd1;
            m_ff       <= $signed({24'd0, req_data.measure_in}) - 40'sd1;
            b_ff       <= $signed({8'd0, req_data.beat_in}) - 16'sd1;
            t_ff       <= $signed({2'b00, req_data.tick_value});
         end
         OP_INS_STEP: begin
            prev_num_ff <= rdata_ff.num;
            prev_den_ff <= rdata_ff.den;
            idx_ff      <= idx_ff + CNT_W'(1);
         end
         OP_REM_INIT:  sp_ff <= idx_ff + CNT_W'(1);
         OP_REM_WRITE: sp_ff <= sp_ff + CNT_W'(1);
         OP_SET_DROP:  status_ff <= ST_DROPPED;
         OP_SET_FULL:  status_ff <= ST_FULL;
         OP_UP_INIT:   sp_ff <= cnt_ff;
         OP_UP_WRITE:  sp_ff <= sp_m1;
         OP_BL_SET:    bl_ff <= (div_q == 31'd0) ? 14'd1 : div_q[13:0];
         OP_ML_SET:    ml_ff <= 22'(bl_ff) * 22'(num_eff);
         OP_REL_CHG:   rel_ff <= rdata_ff.tick - off_ff;
         OP_REL_FINAL: rel_ff <= tick_ff - off_ff;
         OP_MEAS_ADD:  meas_ff <= meas_ff + {1'b0, div_q};
         OP_ADVANCE: begin
            off_ff     <= rdata_ff.tick;
            cur_num_ff <= rdata_ff.num;
            cur_den_ff <= rdata_ff.den;
            idx_ff     <= idx_ff + CNT_W'(1);
         end
         OP_T2L_FIN: begin
            beat_ff <= div_q[7:0] + 8'd1;
            bt_ff   <= (|div_r[21:12]) ? 12'd4095 : div_r[11:0];
         end
         OP_TGT_INIT: begin
            acc_ff    <= 64'(t_ff) + $signed({33'd0, off_ff});
            mcand_ff  <= 64'(m_ff);
            mplier_ff <= ml_ff;
         end
         OP_MUL_STEP: begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff <<< 1;
            mplier_ff <= mplier_ff >> 1;
         end
         OP_TGT_B: begin
            mcand_ff  <= 64'(b_ff);
            mplier_ff <= {8'd0, bl_ff};
         end
         OP_SUB_M: m_ff <= m_ff - $signed({9'd0, div_q});
         OP_SUB_BT: begin
            b_ff <= b_ff - $signed({8'd0, div_q[7:0]});
            t_ff <= t_ff - $signed({19'd0, div_r[13:0]});
         end
         OP_EMIT: rsp_ff <= rsp_next;
         default: begin
         end
      endcase
   end

   always_comb begin
      dp_status.cmd       = cmd_ff;
      dp_status.idx_end   = idx_ff == cnt_ff;
      dp_status.sp_at_cnt = sp_ff == cnt_ff;
      dp_status.sp_at_idx = sp_ff == idx_ff;
      dp_status.tick_eq   = tick_ff == rdata_ff.tick;
      dp_status.tick_lt   = tick_ff < rdata_ff.tick;
      dp_status.redundant = (idx_ff != '0) && (prev_num_ff == num_ff)
                            && (prev_den_ff == den_ff);
      dp_status.full      = cnt_ff == CNT_W'(TABLE_DEPTH);
      dp_status.div_busy  = div_busy;
      dp_status.mul_zero  = mplier_ff == '0;
      dp_status.t2l_stop  = tick_ff <= rdata_ff.tick;
      dp_status.l2t_stop  = $signed({33'd0, rdata_ff.tick}) > acc_ff;
   end

   assign rsp_data = rsp_ff;

endmodule

### design/tsm_ctrl.sv
// Controller: sequences insert, tick-to-location and location-to-tick walks.
// Depends on tsm_pkg; issues dp_op_type commands to tsm_dpath.
module tsm_ctrl
   import tsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type dp_status,
   output dp_op_type     op
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_CHK,
      S_INS_CMP,
      S_REM_CHK,
      S_REM_WR,
      S_DECIDE,
      S_UP_CHK,
      S_UP_WR,
      S_SIG_DIV,
      S_SIG_WAIT,
      S_SIG_ML,
      S_T2L_CHK,
      S_T2L_CMP,
      S_T2L_QDIV,
      S_T2L_QWAIT,
      S_T2L_FDIV,
      S_T2L_FWAIT,
      S_T2L_RDIV,
      S_T2L_RWAIT,
      S_ADV,
      S_L2T_TGT,
      S_L2T_MUL,
      S_L2T_MULB,
      S_L2T_CHK,
      S_L2T_CMP,
      S_L2T_QDIV,
      S_L2T_QWAIT,
      S_L2T_RDIV,
      S_L2T_RWAIT,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      op           = OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (dp_status.cmd)
               CMD_INSERT:      state_in = S_INS_CHK;
               CMD_TICK_TO_LOC: state_in = S_SIG_DIV;
               CMD_LOC_TO_TICK: state_in = S_SIG_DIV;
               default:         state_in = S_EMIT;
            endcase
         end
         // insert: find slot, drop a same-tick entry, then reject if redundant or full, else shift up
         S_INS_CHK: begin
            if (dp_status.idx_end) begin
               state_in = S_DECIDE;
            end else begin
               op       = OP_READ_IDX;
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (dp_status.tick_eq) begin
               op       = OP_REM_INIT;
               state_in = S_REM_CHK;
            end else if (dp_status.tick_lt) begin
               state_in = S_DECIDE;
            end else begin
               op       = OP_INS_STEP;
               state_in = S_INS_CHK;
            end
         end
         S_REM_CHK: begin
            if (dp_status.sp_at_cnt) begin
               op       = OP_CNT_DEC;
               state_in = S_DECIDE;
            end else begin
               op       = OP_READ_SP;
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            op       = OP_REM_WRITE;
            state_in = S_REM_CHK;
         end
         S_DECIDE: begin
            if (dp_status.redundant) begin
               op       = OP_SET_DROP;
               state_in = S_EMIT;
            end else if (dp_status.full) begin
               op       = OP_SET_FULL;
               state_in = S_EMIT;
            end else begin
               op       = OP_UP_INIT;
               state_in = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            if (dp_status.sp_at_idx) begin
               op       = OP_INS_WRITE;
               state_in = S_EMIT;
            end else begin
               op       = OP_READ_SPM;
               state_in = S_UP_WR;
            end
         end
         S_UP_WR: begin
            op       = OP_UP_WRITE;
            state_in = S_UP_CHK;
         end
         // beat and measure length of the current signature
         S_SIG_DIV: begin
            op       = OP_DIV_BL;
            state_in = S_SIG_WAIT;
         end
         S_SIG_WAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_BL_SET;
               state_in = S_SIG_ML;
            end
         end
         S_SIG_ML: begin
            op = OP_ML_SET;
            if (dp_status.cmd == CMD_LOC_TO_TICK) begin
               state_in = S_L2T_TGT;
            end else begin
               state_in = S_T2L_CHK;
            end
         end
         S_T2L_CHK: begin
            if (dp_status.idx_end) begin
               op       = OP_REL_FINAL;
               state_in = S_T2L_FDIV;
            end else begin
               op       = OP_READ_IDX;
               state_in = S_T2L_CMP;
            end
         end
         S_T2L_CMP: begin
            if (dp_status.t2l_stop) begin
               op       = OP_REL_FINAL;
               state_in = S_T2L_FDIV;
            end else begin
               op       = OP_REL_CHG;
               state_in = S_T2L_QDIV;
            end
         end
         S_T2L_QDIV: begin
            op       = OP_DIV_REL;
            state_in = S_T2L_QWAIT;
         end
         S_T2L_QWAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_MEAS_ADD;
               state_in = S_ADV;
            end
         end
         S_T2L_FDIV: begin
            op       = OP_DIV_REL;
            state_in = S_T2L_FWAIT;
         end
         S_T2L_FWAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_MEAS_ADD;
               state_in = S_T2L_RDIV;
            end
         end
         S_T2L_RDIV: begin
            op       = OP_DIV_REM;
            state_in = S_T2L_RWAIT;
         end
         S_T2L_RWAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_T2L_FIN;
               state_in = S_EMIT;
            end
         end
         S_ADV: begin
            op       = OP_ADVANCE;
            state_in = S_SIG_DIV;
         end
         // target = tpm*m + tpb*b + t + off, two serial multiplies
         S_L2T_TGT: begin
            op       = OP_TGT_INIT;
            state_in = S_L2T_MUL;
         end
         S_L2T_MUL: begin
            if (dp_status.mul_zero) begin
               op       = OP_TGT_B;
               state_in = S_L2T_MULB;
            end else begin
               op = OP_MUL_STEP;
            end
         end
         S_L2T_MULB: begin
            if (dp_status.mul_zero) begin
               state_in = S_L2T_CHK;
            end else begin
               op = OP_MUL_STEP;
            end
         end
         S_L2T_CHK: begin
            if (dp_status.idx_end) begin
               state_in = S_EMIT;
            end else begin
               op       = OP_READ_IDX;
               state_in = S_L2T_CMP;
            end
         end
         S_L2T_CMP: begin
            if (dp_status.l2t_stop) begin
               state_in = S_EMIT;
            end else begin
               op       = OP_REL_CHG;
               state_in = S_L2T_QDIV;
            end
         end
         S_L2T_QDIV: begin
            op       = OP_DIV_REL;
            state_in = S_L2T_QWAIT;
         end
         S_L2T_QWAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_SUB_M;
               state_in = S_L2T_RDIV;
            end
         end
         S_L2T_RDIV: begin
            op       = OP_DIV_REM;
            state_in = S_L2T_RWAIT;
         end
         S_L2T_RWAIT: begin
            if (!dp_status.div_busy) begin
               op       = OP_SUB_BT;
               state_in = S_ADV;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op           = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/time_signature_map_unit.sv
// Time-signature map, one command at a time; a finished beat waits in the rsp register.
// Insert scans the table for the slot and moves the later entries up.
// Conversions run on the shared divider and walk each change passed; location to tick
// also uses bit-serial multiplies.
// Synchronous reset empties the table and sets ticks_per_quarter to 480; no clearing pass.
module time_signature_map_unit
   import tsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   dp_status_type dp_status;
   dp_op_type     op;

   tsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .op        (op)
   );

   tsm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .op          (op),
      .dp_status   (dp_status),
      .rsp_data    (rsp_data)
   );

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !dp_status.div_busy)
      else $error("divider still busy while idle");

   a_beat_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.measure_out != 16'd0) |-> rsp_data.beat_out != 8'd0)
      else $error("location result with zero beat");

   a_status_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_DONE)
         |-> (rsp_data.result_tick == '0 && rsp_data.measure_out == '0))
      else $error("insert status mixed with conversion fields");

endmodule

### tb/tb_time_signature_map_unit.sv
// Self-checking testbench for time_signature_map_unit: insert, tick-to-location,
// location-to-tick and unknown-command beats, compared against an in-bench model. Depends on tsm_pkg.
`timescale 1ns / 1ps

module tb_time_signature_map_unit;
   import tsm_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [11:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;

   time_signature_map_unit dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   // model state
   logic [11:0] tpq;
   logic [30:0] sig_tick [TABLE_DEPTH];
   logic [7:0]  sig_num  [TABLE_DEPTH];
   logic [6:0]  sig_den  [TABLE_DEPTH];
   int          sig_count;

   rsp_type expected_rsps[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      idle_count = 0;

   function automatic longint beat_ticks(logic [6:0] den);
      longint d, q;
      d = (den == 0) ? 1 : den;
      q = (longint'(tpq) * 4) / d;
      return (q == 0) ? 1 : q;
   endfunction

   function automatic longint measure_ticks(logic [7:0] num, logic [6:0] den);
      return beat_ticks(den) * ((num == 0) ? 1 : num);
   endfunction

   function automatic logic [1:0] apply_insert(logic [30:0] t, logic [7:0] n, logic [6:0] d);
      int i, j;
      for (i = 0; i < sig_count; i++) begin
         if (t == sig_tick[i]) begin
            for (j = i; j < sig_count - 1; j++) begin
               sig_tick[j] = sig_tick[j+1];
               sig_num[j]  = sig_num[j+1];
               sig_den[j]  = sig_den[j+1];
            end
            sig_count--;
            break;
         end
         if (t < sig_tick[i]) break;
      end
      if (i > 0 && sig_num[i-1] == n && sig_den[i-1] == d) return ST_DROPPED;
      if (sig_count >= TABLE_DEPTH) return ST_FULL;
      for (j = sig_count; j > i; j--) begin
         sig_tick[j] = sig_tick[j-1];
         sig_num[j]  = sig_num[j-1];
         sig_den[j]  = sig_den[j-1];
      end
      sig_tick[i] = t;
      sig_num[i]  = n;
      sig_den[i]  = d;
      sig_count++;
      return ST_DONE;
   endfunction

   function automatic logic [30:0] location_tick(logic [15:0] mi, logic [7:0] bi,
                                                 logic [30:0] ti);
      longint m, b, t, off, tpb, tpm, et, rel, r;
      m = longint'(mi) - 1;
      b = longint'(bi) - 1;
      t = ti;
      off = 0;
      tpb = beat_ticks(7'd4);
      tpm = tpb * 4;
      for (int i = 0; i < sig_count; i++) begin
         et = sig_tick[i];
         if (et > tpm * m + tpb * b + t + off) break;
         rel = et - off;
         m -= rel / tpm;
         b -= (rel % tpm) / tpb;
         t -= rel % tpb;
         tpb = beat_ticks(sig_den[i]);
         tpm = measure_ticks(sig_num[i], sig_den[i]);
         off = et;
      end
      r = tpm * m + tpb * b + t + off;
      if (r < 0) return '0;
      if (r > 64'h7FFF_FFFF) return 31'h7FFF_FFFF;
      return r[30:0];
   endfunction

   function automatic rsp_type predict_rsp(req_type rq);
      rsp_type    rs;
      longint     meas, off, rel, bl, ml, bt;
      logic [7:0] n;
      logic [6:0] d;
      rs = '0;
      case (rq.cmd)
         CMD_INSERT: begin
            rs.status = apply_insert(rq.tick_value, rq.sig_numerator, rq.sig_denominator);
         end
         CMD_TICK_TO_LOC: begin
            meas = 1; off = 0; n = DEFAULT_NUM; d = DEFAULT_DEN;
            for (int i = 0; i < sig_count; i++) begin
               if (rq.tick_value <= sig_tick[i]) break;
               meas += (longint'(sig_tick[i]) - off) / measure_ticks(n, d);
               off = sig_tick[i];
               n = sig_num[i];
               d = sig_den[i];
            end
            rel = longint'(rq.tick_value) - off;
            bl = beat_ticks(d);
            ml = measure_ticks(n, d);
            meas += rel / ml;
            rs.measure_out = (meas > 65535) ? 16'hFFFF : meas[15:0];
            rs.beat_out = 8'((rel % ml) / bl + 1);
            bt = rel % bl;
            rs.beat_tick_out = (bt > 4095) ? 12'hFFF : bt[11:0];
         end
         CMD_LOC_TO_TICK: begin
            rs.result_tick = location_tick(rq.measure_in, rq.beat_in, rq.tick_value);
         end
         default: ;
      endcase
      return rs;
   endfunction

   task automatic send_req(req_type rq);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clock);
      req_data <= rq;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_rsps.push_back(predict_rsp(rq));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_fields(logic [1:0] c, logic [30:0] tv, logic [15:0] mi, logic [7:0] bi,
                              logic [7:0] n, logic [6:0] d);
      req_type rq;
      rq = '{cmd: c, tick_value: tv, measure_in: mi, beat_in: bi,
             sig_numerator: n, sig_denominator: d};
      send_req(rq);
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_tpq(logic [11:0] v);
      wait_drained();
      csr_wr_data <= v;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      tpq = v;
   endtask

   // receiver stall and result checking
   always @(negedge clock)
      rsp_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type exp_rsp;
            exp_rsp = expected_rsps.pop_front();
            if (rsp_data.status !== exp_rsp.status)
               $display("%0t: status exp %0d got %0d", $time, exp_rsp.status, rsp_data.status);
            if (rsp_data.result_tick !== exp_rsp.result_tick)
               $display("%0t: result_tick exp %0d got %0d", $time,
                        exp_rsp.result_tick, rsp_data.result_tick);
            if (rsp_data.measure_out !== exp_rsp.measure_out)
               $display("%0t: measure_out exp %0d got %0d", $time,
                        exp_rsp.measure_out, rsp_data.measure_out);
            if (rsp_data.beat_out !== exp_rsp.beat_out)
               $display("%0t: beat_out exp %0d got %0d", $time,
                        exp_rsp.beat_out, rsp_data.beat_out);
            if (rsp_data.beat_tick_out !== exp_rsp.beat_tick_out)
               $display("%0t: beat_tick_out exp %0d got %0d", $time,
                        exp_rsp.beat_tick_out, rsp_data.beat_tick_out);
            if (rsp_data !== exp_rsp) errors++;
         end
      end
   end

   // watchdog: cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic test_directed();
      send_fields(CMD_TICK_TO_LOC, 31'd0, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_TICK_TO_LOC, 31'h7FFF_FFFF, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'd0, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 7'h7F);
      send_fields(CMD_INSERT, 31'd1920, 16'd0, 8'd0, 8'd3, 7'd4);
      send_fields(CMD_INSERT, 31'd3360, 16'd0, 8'd0, 8'd3, 7'd4);
      send_fields(CMD_INSERT, 31'd1920, 16'd0, 8'd0, 8'd6, 7'd8);
      send_fields(CMD_INSERT, 31'd0, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_INSERT, 31'd9000, 16'd0, 8'd0, 8'd5, 7'd3);
      send_fields(CMD_INSERT, 31'h7FFF_FFFF, 16'd0, 8'd0, 8'd255, 7'd127);
      send_fields(CMD_TICK_TO_LOC, 31'd5000, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_TICK_TO_LOC, 31'd1920, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'd17, 16'd3, 8'd2, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'd5, 16'd1, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_UNKNOWN, 31'h7FFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF, 7'h7F);
   endtask

   task automatic test_big_beat();
      write_tpq(12'd4095);
      send_fields(CMD_INSERT, 31'd100, 16'd0, 8'd0, 8'd1, 7'd1);
      send_fields(CMD_TICK_TO_LOC, 31'd100000, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_TICK_TO_LOC, 31'h7FFF_FFFF, 16'd0, 8'd0, 8'd0, 7'd0);
      write_tpq(12'd0);
      send_fields(CMD_TICK_TO_LOC, 31'd12345, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'd3, 16'd9, 8'd2, 8'd0, 7'd0);
      write_tpq(12'd1);
      send_fields(CMD_INSERT, 31'd50, 16'd0, 8'd0, 8'd7, 7'd64);
      send_fields(CMD_TICK_TO_LOC, 31'd777, 16'd0, 8'd0, 8'd0, 7'd0);
   endtask

   task automatic test_fill_table();
      // TABLE_DEPTH + 3 inserts at distinct ticks with alternating signatures, past full, then one more
      for (int i = 0; i < TABLE_DEPTH + 3; i++)
         send_fields(CMD_INSERT, 31'(20000 + i * 97), 16'd0, 8'd0,
                     8'((i % 2) ? 2 : 7), 7'd8);
      send_fields(CMD_INSERT, 31'(20000 + 97 * 70), 16'd0, 8'd0, 8'd2, 7'd8);
      send_fields(CMD_TICK_TO_LOC, 31'd30000, 16'd0, 8'd0, 8'd0, 7'd0);
      send_fields(CMD_LOC_TO_TICK, 31'd11, 16'd40, 8'd3, 8'd0, 7'd0);
   endtask

   task automatic random_item();
      req_type     rq;
      logic [95:0] rnd;
      int          k;
      rnd = {$urandom, $urandom, $urandom};
      rq = rnd[$bits(req_type)-1:0];
      k = $urandom_range(99);
      if (k < 30) begin
         rq.cmd = CMD_INSERT;
         if (k < 24) begin
            rq.tick_value = 31'($urandom_range(20000));
            rq.sig_numerator = 8'($urandom_range(1, 12));
            rq.sig_denominator = 7'(1 << $urandom_range(6));
         end
      end else if (k < 62) begin
         rq.cmd = CMD_TICK_TO_LOC;
         if (k < 55) rq.tick_value = 31'($urandom_range(40000));
      end else if (k < 96) begin
         rq.cmd = CMD_LOC_TO_TICK;
         if (k < 88) begin
            rq.measure_in = 16'($urandom_range(1, 30));
            rq.beat_in = 8'($urandom_range(1, 8));
            rq.tick_value = 31'($urandom_range(1000));
         end
      end else rq.cmd = CMD_UNKNOWN;
      send_req(rq);
   endtask

   task automatic test_random();
      logic [11:0] tpq_set [4] = '{12'd480, 12'd96, 12'd3840, 12'd7};
      for (int ph = 0; ph < 4; ph++) begin
         write_tpq(tpq_set[ph]);
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 26 : 52) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 26 : 52) : 0;
         for (int i = 0; i < 215; i++) begin
            if (i == 100) wait_drained();
            random_item();
         end
      end
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   initial begin
      tpq = TPQ_RESET;
      sig_count = 0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_big_beat();
      test_fill_table();
      test_random();
      wait_drained();
      repeat (300) @(negedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### files.f
design/tsm_pkg.sv
design/tsm_div.sv
design/tsm_dpath.sv
design/tsm_ctrl.sv
design/time_signature_map_unit.sv
tb/tb_time_signature_map_unit.sv
